// ===== src/gbs_pkg.sv =====
package gbs_pkg;

    // Kept-list geometry
    localparam int MAX_KEPT = 256;
    localparam int KEPT_AW  = $clog2(MAX_KEPT);
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;
    localparam int THR_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = CFG_IDX_W'(1);

    // 0.45 rounded to Q1.8
    localparam logic [THR_W-1:0] THR_RESET      = THR_W'(115);
    localparam logic             AGNOSTIC_RESET = 1'b0;

    typedef struct packed {
        logic               start_frame;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic        [15:0] box_width;
        logic        [15:0] box_height;
        logic        [7:0]  class_label;
    } t_box_in;

    typedef struct packed {
        logic       keep;
        logic [7:0] kept_index;
        logic       store_full;
    } t_box_out;

    // One kept-list entry as stored in the RAM
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
        logic        [31:0] area;
        logic        [7:0]  cls;
    } t_kept_entry;

    localparam int ENTRY_W = $bits(t_kept_entry);

    typedef struct packed {
        logic               latch;
        logic               rd_en;
        logic [KEPT_AW-1:0] rd_addr;
        logic               finish;
        logic               room;
        logic [KEPT_AW-1:0] wr_slot;
    } t_ctl_cmd;

    typedef struct packed {
        logic busy;
        logic suppress;
    } t_dp_status;

endpackage

// ===== src/greedy_box_suppression.sv =====
// Channel   Direction  Handshake             Payload
// in        input      i_in_valid/o_in_stall i_in_data  (gbs_pkg::t_box_in)
// out       output     o_out_valid/i_out_stall o_out_data (gbs_pkg::t_box_out)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// With N boxes kept so far in the frame (at most MAX_KEPT), a box's result is
// registered once the scan of those N entries and the drain behind it are done.
// The kept-list RAM has one read port, so the scan reads one kept entry per
// cycle; the read register and four compare stages drain behind it only as
// long as the latest overlapping entry needs. The input stalls until the
// result is registered, so no two boxes are scanned at once.
// Reset is synchronous, active low; it empties the kept list and loads the
// register defaults. A stalled result holds in the output register while
// the next box is already accepted and scanned; that box then waits to finish.
module greedy_box_suppression (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gbs_pkg::t_box_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gbs_pkg::t_box_out              o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gbs_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    // Registers accept a write in any cycle
    assign o_cfg_ready = 1'b1;

    // Sequence each transaction: scan, drain, finish
    gbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_start  (i_in_data.start_frame),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Hold the box, the kept list and the overlap test
    gbs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ===== src/gbs_ram.sv =====
module gbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/gbs_ctrl.sv =====
module gbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_start,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  gbs_pkg::t_dp_status i_status,
    output gbs_pkg::t_ctl_cmd   o_cmd
);
    import gbs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_scan;
    logic [CNT_W-1:0] r_count;
    logic             r_out_valid;
    logic             out_free;
    logic             scan_done;
    logic             room;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_done = (r_scan == r_count);
    assign room      = (r_count != CNT_W'(MAX_KEPT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise the result as the box finishes; drop it once taken
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_scan <= '0;
                        if (i_in_start) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_scan <= r_scan + CNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!i_status.busy) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (!i_status.suppress && room) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.latch   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en   = (r_state == S_SCAN) && !scan_done;
        o_cmd.rd_addr = r_scan[KEPT_AW-1:0];
        o_cmd.finish  = (r_state == S_FINISH) && out_free;
        o_cmd.room    = room;
        o_cmd.wr_slot = r_count[KEPT_AW-1:0];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/gbs_datapath.sv =====
module gbs_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbs_pkg::t_box_in             i_in_data,
    output gbs_pkg::t_box_out            o_out_data,
    input  logic                         i_cfg_wr,
    input  logic [gbs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  gbs_pkg::t_ctl_cmd            i_cmd,
    output gbs_pkg::t_dp_status          o_status
);
    import gbs_pkg::*;

    // Configuration
    logic [THR_W-1:0] r_thr;
    logic             r_agnostic;

    // Current box
    t_box_in            r_box;
    logic signed [17:0] r_right;
    logic signed [17:0] r_bottom;
    logic        [31:0] r_area;
    logic               r_suppress;

    // Kept-list RAM
    t_kept_entry        wr_entry;
    logic [ENTRY_W-1:0] rd_word;
    t_kept_entry        rd_entry;
    logic               wr_en;
    logic               r_rd_q;

    // Stage 1: overlap extents
    logic signed [17:0] box_left18;
    logic signed [17:0] box_top18;
    logic signed [17:0] k_left18;
    logic signed [17:0] k_top18;
    logic signed [17:0] min_r;
    logic signed [17:0] max_l;
    logic signed [17:0] min_b;
    logic signed [17:0] max_t;
    logic        [18:0] ix;
    logic        [18:0] iy;
    logic               ix_pos;
    logic               iy_pos;
    logic               cls_match;
    logic               r_s1_vld;
    logic        [15:0] r_s1_ix;
    logic        [15:0] r_s1_iy;
    logic        [31:0] r_s1_karea;

    // Stage 2: intersection
    logic        r_s2_vld;
    logic [31:0] r_s2_inter;
    logic [31:0] r_s2_karea;

    // Stage 3: union
    logic        r_s3_vld;
    logic [31:0] r_s3_inter;
    logic [32:0] r_s3_uni;

    // Stage 4: scaled sides of the test
    logic        r_s4_vld;
    logic [39:0] r_s4_lhs;
    logic [41:0] r_s4_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_agnostic <= AGNOSTIC_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_IOU_THRESHOLD:  r_thr      <= i_cfg_data[THR_W-1:0];
                CFG_CLASS_AGNOSTIC: r_agnostic <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Hold the box; its far edges and area are registered from it in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_box <= i_in_data;
        end
        r_right  <= {{2{r_box.box_x[15]}}, r_box.box_x} + $signed({2'b00, r_box.box_width});
        r_bottom <= {{2{r_box.box_y[15]}}, r_box.box_y} + $signed({2'b00, r_box.box_height});
        r_area   <= r_box.box_width * r_box.box_height;
    end

    always_comb begin
        wr_entry.left   = r_box.box_x;
        wr_entry.top    = r_box.box_y;
        wr_entry.right  = r_right;
        wr_entry.bottom = r_bottom;
        wr_entry.area   = r_area;
        wr_entry.cls    = r_box.class_label;
    end

    assign wr_en = i_cmd.finish && !r_suppress && i_cmd.room;

    gbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_cmd.wr_slot),
        .i_wr_data (wr_entry),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    always_comb begin
        box_left18 = {{2{r_box.box_x[15]}}, r_box.box_x};
        box_top18  = {{2{r_box.box_y[15]}}, r_box.box_y};
        k_left18   = {{2{rd_entry.left[15]}}, rd_entry.left};
        k_top18    = {{2{rd_entry.top[15]}}, rd_entry.top};
        min_r      = (r_right  < rd_entry.right)  ? r_right  : rd_entry.right;
        min_b      = (r_bottom < rd_entry.bottom) ? r_bottom : rd_entry.bottom;
        max_l      = (box_left18 > k_left18) ? box_left18 : k_left18;
        max_t      = (box_top18  > k_top18)  ? box_top18  : k_top18;
        ix         = {min_r[17], min_r} - {max_l[17], max_l};
        iy         = {min_b[17], min_b} - {max_t[17], max_t};
        ix_pos     = !ix[18] && (ix != '0);
        iy_pos     = !iy[18] && (iy != '0);
        cls_match  = r_agnostic || (rd_entry.cls == r_box.class_label);
    end

    // Boxes with no overlap, or of another class outside agnostic mode, can never suppress: drop them early
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_q   <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_rd_q   <= i_cmd.rd_en;
            r_s1_vld <= r_rd_q && cls_match && ix_pos && iy_pos;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ix    <= ix[15:0];
        r_s1_iy    <= iy[15:0];
        r_s1_karea <= rd_entry.area;
        r_s2_inter <= r_s1_ix * r_s1_iy;
        r_s2_karea <= r_s1_karea;
        r_s3_inter <= r_s2_inter;
        r_s3_uni   <= {1'b0, r_area} + {1'b0, r_s2_karea} - {1'b0, r_s2_inter};
        r_s4_lhs   <= {r_s3_inter, 8'h00};
        r_s4_rhs   <= r_thr * r_s3_uni;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_suppress <= 1'b0;
        end else if (r_s4_vld && ({2'b00, r_s4_lhs} > r_s4_rhs)) begin
            r_suppress <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_data.keep       <= !r_suppress;
            o_out_data.store_full <= !r_suppress && !i_cmd.room;
            o_out_data.kept_index <= (!r_suppress && i_cmd.room) ? 8'(i_cmd.wr_slot) : 8'h00;
        end
    end

    assign o_status.busy     = r_rd_q || r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;
    assign o_status.suppress = r_suppress;

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbs_pkg::*;

    // Slowest correct run: about 2000 boxes, each at worst scanning a full kept list,
    // plus sender gaps and receiver stalls, plus one long hold.
    // CYCLE_LIMIT allows a few times the length of that run.
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 210;

    // Unmapped register index; a write there must leave both registers alone
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(15);

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_box_in               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_box_out              o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    greedy_box_suppression dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the kept list and the registers.
    // Geometry is held in 64-bit signed so that the far edges and the
    // products never wrap.
    // ------------------------------------------------------------------
    longint           kbox_l    [MAX_KEPT];
    longint           kbox_t    [MAX_KEPT];
    longint           kbox_r    [MAX_KEPT];
    longint           kbox_b    [MAX_KEPT];
    longint           kbox_area [MAX_KEPT];
    logic [7:0]       kbox_cls  [MAX_KEPT];
    int               kbox_cnt    = 0;
    logic [THR_W-1:0] thr_q8      = THR_RESET;
    logic             agnostic_on = AGNOSTIC_RESET;

    // Verdicts still owed by the block, oldest first
    t_box_out verdict_q [$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Sender pacing
    bit pacing_on  = 1'b1;
    int burst_left = 0;

    // Long receiver hold-off: bump hold_seq to request one
    int hold_seq = 0;

    // Work out the verdict for one box and update the kept list the way the
    // block must: compare against every kept box of the same class (or all
    // classes in agnostic mode), suppress on inter*256 > thr*union.
    function automatic t_box_out nms_verdict(t_box_in b);
        longint   lft, top, rgt, bot, wid, hgt, area;
        longint   ix, iy, inter, uni;
        logic     keep;
        int       i;
        t_box_out r;
        lft  = b.box_x;
        top  = b.box_y;
        wid  = b.box_width;
        hgt  = b.box_height;
        rgt  = lft + wid;
        bot  = top + hgt;
        area = wid * hgt;
        keep = 1'b1;
        if (b.start_frame)
            kbox_cnt = 0;
        for (i = 0; i < kbox_cnt; i++) begin
            if (!agnostic_on && kbox_cls[i] != b.class_label)
                continue;
            ix = ((rgt < kbox_r[i]) ? rgt : kbox_r[i]) - ((lft > kbox_l[i]) ? lft : kbox_l[i]);
            iy = ((bot < kbox_b[i]) ? bot : kbox_b[i]) - ((top > kbox_t[i]) ? top : kbox_t[i]);
            inter = (ix > 0 && iy > 0) ? ix * iy : 0;
            // Zero union only happens with zero inter, so 0 > 0 never suppresses
            uni = area + kbox_area[i] - inter;
            if (inter * 256 > longint'(thr_q8) * uni)
                keep = 1'b0;
        end
        r      = '0;
        r.keep = keep;
        if (keep) begin
            if (kbox_cnt < MAX_KEPT) begin
                kbox_l[kbox_cnt]    = lft;
                kbox_t[kbox_cnt]    = top;
                kbox_r[kbox_cnt]    = rgt;
                kbox_b[kbox_cnt]    = bot;
                kbox_area[kbox_cnt] = area;
                kbox_cls[kbox_cnt]  = b.class_label;
                r.kept_index        = 8'(kbox_cnt);
                kbox_cnt++;
            end else begin
                // Full list: report it, store nothing
                r.store_full = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_box_in mk_box(bit sf, int x, int y, int w, int h, int cls);
        t_box_in b;
        b.start_frame = sf;
        b.box_x       = 16'(x);
        b.box_y       = 16'(y);
        b.box_width   = 16'(w);
        b.box_height  = 16'(h);
        b.class_label = 8'(cls);
        return b;
    endfunction

    // Mostly moderate sizes, with zero and full-range ones mixed in
    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2:    return 16'($urandom);
            default: return 16'($urandom_range(1, 1024));
        endcase
    endfunction

    // Random offset in +/- span/4
    function automatic logic [15:0] jitter(logic [15:0] span);
        int r;
        r = span >> 2;
        return 16'($urandom_range(0, 2 * r)) - 16'(r);
    endfunction

    // Offer one box, hold it until accepted, record its verdict, then
    // maybe close the burst with a gap.
    task automatic send_box(input t_box_in b);
        int       gap;
        t_box_out owed;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        owed      = nms_verdict(b);
        verdict_q = {verdict_q, owed};
        if (pacing_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap        = $urandom_range(0, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // One register write; call only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_IOU_THRESHOLD:  thr_q8      = val;
            CFG_CLASS_AGNOSTIC: agnostic_on = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and let every owed verdict come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Identical, shifted, touching, other-class, extreme and zero-area boxes
    // at the reset threshold.
    task automatic test_overlap_basics();
        send_box(mk_box(1, 0, 0, 256, 256, 3));
        send_box(mk_box(0, 0, 0, 256, 256, 3));          // duplicate: suppressed
        send_box(mk_box(0, 0, 0, 256, 256, 4));          // other class: kept
        send_box(mk_box(0, -32768, -32768, 65535, 65535, 255));
        send_box(mk_box(0, 32767, 32767, 65535, 65535, 255)); // corner touch only
        send_box(mk_box(0, 0, 0, 0, 0, 7));
        send_box(mk_box(0, 0, 0, 0, 0, 7));              // zero union
        send_box(mk_box(0, 128, 0, 256, 256, 3));        // IoU 1/3: below limit
        send_box(mk_box(0, 64, 0, 256, 256, 3));         // IoU 0.6: suppressed
        send_box(mk_box(0, 256, 0, 256, 256, 3));
        send_box(mk_box(1, 0, 0, 256, 256, 4));          // new frame: slot 0 again
    endtask

    // Threshold at 0, 256, 511 and 255, agnostic on and off, unmapped index
    task automatic test_reg_extremes();
        wait_idle();
        write_reg(CFG_IOU_THRESHOLD, 9'd0);
        write_reg(CFG_CLASS_AGNOSTIC, 9'h101);
        send_box(mk_box(1, 0, 0, 16, 16, 1));
        send_box(mk_box(0, 15, 15, 16, 16, 9));          // any overlap suppresses
        send_box(mk_box(0, 16, 0, 16, 16, 1));           // touching edge: kept
        wait_idle();
        write_reg(CFG_IOU_THRESHOLD, 9'd256);
        send_box(mk_box(0, 0, 0, 16, 16, 2));            // inter == union: kept
        wait_idle();
        write_reg(CFG_IOU_THRESHOLD, 9'd511);
        write_reg(CFG_CLASS_AGNOSTIC, 9'h0FE);
        send_box(mk_box(0, 0, 0, 16, 16, 1));
        wait_idle();
        write_reg(CFG_SPARE, 9'h1FF);
        write_reg(CFG_IOU_THRESHOLD, 9'd255);
        send_box(mk_box(0, 0, 0, 16, 16, 1));            // exact duplicate at 255
        wait_idle();
        write_reg(CFG_IOU_THRESHOLD, THR_RESET);
        write_reg(CFG_CLASS_AGNOSTIC, 9'(AGNOSTIC_RESET));
    endtask

    // Fill every slot with boxes of distinct classes, then overflow
    task automatic test_store_full();
        int i;
        wait_idle();
        send_box(mk_box(1, 0, 0, 512, 512, 0));
        for (i = 1; i < MAX_KEPT; i++)
            send_box(mk_box(0, $urandom, $urandom, pick_size(), pick_size(), i));
        send_box(mk_box(0, 8192, 8192, 512, 512, 0));    // kept, flagged full
        send_box(mk_box(0, 8192, 8192, 512, 512, 0));    // overflow box was not stored
        send_box(mk_box(0, 0, 0, 512, 512, 0));          // still suppressed by slot 0
        send_box(mk_box(1, 0, 0, 512, 512, 0));          // new frame frees the list
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering boxes back to back; the block must fill and stall its input.
    task automatic test_backpressure();
        int i;
        wait_idle();
        pacing_on = 1'b0;
        hold_seq++;
        for (i = 0; i < 48; i++)
            send_box(mk_box(i % 6 == 0, 16'($urandom_range(0, 2000)),
                            16'($urandom_range(0, 2000)), $urandom_range(16, 600),
                            $urandom_range(16, 600), $urandom_range(0, 1)));
        pacing_on = 1'b1;
    endtask

    // Frames of clustered boxes around a few objects, with some noise boxes
    // and the odd frame restart in the middle.
    task automatic test_random_frames();
        int          phase, n, len, k, na, a;
        logic [15:0] ax [4];
        logic [15:0] ay [4];
        logic [15:0] aw [4];
        logic [15:0] ah [4];
        logic [7:0]  ac [4];
        logic [8:0]  thr;
        t_box_in     b;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       thr = 9'd0;
                1:       thr = 9'd256;
                2:       thr = 9'd511;
                3:       thr = 9'd255;
                default: thr = 9'($urandom_range(1, 300));
            endcase
            write_reg(CFG_IOU_THRESHOLD, thr);
            write_reg(CFG_CLASS_AGNOSTIC, {8'($urandom), 1'($urandom)});
            n = 0;
            while (n < RAND_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(1, 24);
                na  = $urandom_range(1, 4);
                for (k = 0; k < na; k++) begin
                    if ($urandom_range(0, 9) < 7) begin
                        ax[k] = 16'($urandom_range(0, 8000)) - 16'd4000;
                        ay[k] = 16'($urandom_range(0, 8000)) - 16'd4000;
                    end else begin
                        ax[k] = 16'($urandom);
                        ay[k] = 16'($urandom);
                    end
                    aw[k] = pick_size();
                    ah[k] = pick_size();
                    ac[k] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 3));
                end
                for (k = 0; k < len && n < RAND_PER_PHASE; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        b.box_x       = 16'($urandom);
                        b.box_y       = 16'($urandom);
                        b.box_width   = 16'($urandom);
                        b.box_height  = 16'($urandom);
                        b.class_label = 8'($urandom);
                    end else begin
                        a             = $urandom_range(0, na - 1);
                        b.box_x       = ax[a] + jitter(aw[a]);
                        b.box_y       = ay[a] + jitter(ah[a]);
                        b.box_width   = aw[a] + jitter(aw[a] >> 1);
                        b.box_height  = ah[a] + jitter(ah[a] >> 1);
                        b.class_label = ac[a];
                    end
                    b.start_frame = (k == 0) || ($urandom_range(0, 49) == 0);
                    send_box(b);
                    n++;
                end
            end
        end
    endtask

    // Receiver: a long hold on request, otherwise a stall pattern that
    // switches between none, light, heavy and periodic every so often.
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_BURSTY: i_out_stall <= ((mode_left % 16) < 5);
                default:      i_out_stall <= 1'b0;
            endcase
        end
    end

    task automatic flag_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
        mismatch_count++;
        $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
    endtask

    // Compare every accepted result with the oldest owed verdict
    always @(posedge i_clk) begin : result_check
        t_box_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (verdict_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual %h",
                         $time, o_out_data);
            end else begin
                want = verdict_q.pop_front();
                if (o_out_data.keep !== want.keep)
                    flag_field("keep", 8'(want.keep), 8'(o_out_data.keep));
                if (o_out_data.kept_index !== want.kept_index)
                    flag_field("kept_index", want.kept_index, o_out_data.kept_index);
                if (o_out_data.store_full !== want.store_full)
                    flag_field("store_full", 8'(want.store_full), 8'(o_out_data.store_full));
            end
        end
    end

    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, verdict_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_overlap_basics();
        test_reg_extremes();
        test_store_full();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/gbs_pkg.sv
src/gbs_ram.sv
src/gbs_ctrl.sv
src/gbs_datapath.sv
src/greedy_box_suppression.sv
bench/tb.sv
